@@ sv/shrb_pkg.sv @@
// Package of shared constants and types for the sequenced history log.
`default_nettype none
package shrb_pkg;
   localparam int CAPACITY      = 1024;
   localparam int RESERVE_DEPTH = 10;
   localparam int PAYLOAD_WIDTH = 64;
   localparam int MAX_BURST     = 32;
   localparam int PTR_W  = $clog2(CAPACITY);
   localparam int HELD_W = $clog2(CAPACITY + 1);
   localparam int RES_W  = $clog2(RESERVE_DEPTH);
   localparam int FILL_W = $clog2(RESERVE_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_READ   = 3'd1,
      OP_CHECK  = 3'd2,
      OP_LOCK   = 3'd3,
      OP_UNLOCK = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_OLD    = 2'd1,
      ST_BEYOND = 2'd2
   } status_type;

   // One memory access request from the sequencer to the log memory.
   typedef struct packed {
      logic                     wr_en;
      logic [PTR_W-1:0]         addr;
      logic [PAYLOAD_WIDTH-1:0] wdata;
   } mem_req_type;
endpackage
`default_nettype wire

@@ sv/shrb_log_ram.sv @@
// Single-port log memory with registered read.
`default_nettype none
module shrb_log_ram (
   input  wire logic                           clock,
   input  wire shrb_pkg::mem_req_type          mem_req,
   output logic [shrb_pkg::PAYLOAD_WIDTH-1:0] rdata
);
   import shrb_pkg::*;

   logic [PAYLOAD_WIDTH-1:0] mem [CAPACITY];

   // Write or read one entry per cycle.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      rdata <= mem[mem_req.addr];
   end
endmodule
`default_nettype wire

@@ sv/sequenced_history_ring_buffer_unit.sv @@
// Top level of the sequenced history log: sequencer, reserve store and outputs.
//
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, operation, entry data, indices, max count
//  rsp     | out       | rsp_valid, rsp_stall, read data, status and window fields, last
//
// A check, a lock, a plain unlock or a push into the reserve goes from idle to the response state.
// A push into the log passes through the write state first; a drain writes each reserve entry in turn.
// A range read of n entries issues each memory read only after the data of the last one has returned.
// Reset clears pointers, counters, lock and fill; the memories are not cleared.
// A stall on rsp holds the result register, and no memory read is issued meanwhile.
`default_nettype none
module sequenced_history_ring_buffer_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [2:0]   req_operation,
   input  wire logic [63:0]  req_entry_data,
   input  wire logic [31:0]  req_start_index,
   input  wire logic [31:0]  req_end_index,
   input  wire logic [5:0]   req_max_count,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [63:0]       rsp_read_data,
   output logic              rsp_data_valid,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_clamped_index,
   output logic [5:0]        rsp_burst_count,
   output logic [31:0]       rsp_first_index,
   output logic [31:0]       rsp_next_index,
   output logic [10:0]       rsp_held_count,
   output logic              rsp_last
);
   import shrb_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DRAIN = 5'b00010,
      S_READ  = 5'b00100,
      S_WAIT  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [31:0]       seq_ff, seq_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              locked_ff, locked_in;
   logic [RES_W-1:0]  didx_ff, didx_in;
   logic              push_after_ff, push_after_in;
   logic [63:0]       pend_ff, pend_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [5:0]        rd_ff, rd_in;       // reads issued
   logic [PTR_W-1:0]  raddr_ff, raddr_in;
   logic              rdv_ff, rdv_in;     // memory data arrives this cycle
   logic              rdlast_ff, rdlast_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [63:0]       o_data_ff, o_data_in;
   logic              o_dv_ff, o_dv_in;
   logic [1:0]        o_st_ff, o_st_in;
   logic [31:0]       o_adj_ff, o_adj_in;
   logic [5:0]        o_cnt_ff, o_cnt_in;
   logic              o_last_ff, o_last_in;
   logic [1:0]        p_st_ff, p_st_in;
   logic [31:0]       p_adj_ff, p_adj_in;

   logic [PAYLOAD_WIDTH-1:0] res_mem [RESERVE_DEPTH];
   logic [PAYLOAD_WIDTH-1:0] res_rdata_ff;
   logic              res_we;
   logic [RES_W-1:0]  res_waddr;
   mem_req_type       mem_req;
   logic [PAYLOAD_WIDTH-1:0] mem_rdata;

   logic [31:0] first_seq, s_off, n_full, held32, chk_back;
   logic [5:0]  n_cnt;
   logic        accept;
   logic        out_free;

   shrb_log_ram u_ram (.clock(clock), .mem_req(mem_req), .rdata(mem_rdata));

   // Reserve store, read through a register at the next drain index (ten entries).
   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_waddr] <= req_entry_data[PAYLOAD_WIDTH-1:0];
      end
      res_rdata_ff <= res_mem[didx_in];
   end

   assign held32    = 32'(held_ff);
   assign first_seq = seq_ff - held32;
   assign chk_back  = first_seq - req_start_index;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;

   // Range bounds relative to the oldest held entry.
   always_comb begin
      logic [31:0] so, eo;
      so = req_start_index - first_seq;
      eo = req_end_index - first_seq;
      if (so[31]) so = '0;
      n_full = '0;
      if (!eo[31]) begin
         if (eo > held32) eo = held32;
         if (eo > so) n_full = eo - so;
      end
      if (n_full > 32'(req_max_count)) n_full = 32'(req_max_count);
      if (n_full > 32'(MAX_BURST)) n_full = 32'(MAX_BURST);
      s_off = so;
      n_cnt = n_full[5:0];
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff; wptr_in = wptr_ff; held_in = held_ff; seq_in = seq_ff;
      fill_in = fill_ff; locked_in = locked_ff; didx_in = didx_ff;
      push_after_in = push_after_ff; pend_in = pend_ff; cnt_in = cnt_ff;
      rd_in = rd_ff; raddr_in = raddr_ff; rdv_in = 1'b0; rdlast_in = 1'b0;
      p_st_in = p_st_ff; p_adj_in = p_adj_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      o_data_in = o_data_ff; o_dv_in = o_dv_ff; o_st_in = o_st_ff;
      o_adj_in = o_adj_ff; o_cnt_in = o_cnt_ff; o_last_in = o_last_ff;
      mem_req = '{wr_en: 1'b0, addr: raddr_ff, wdata: pend_ff[PAYLOAD_WIDTH-1:0]};
      res_we = 1'b0; res_waddr = fill_ff[RES_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_in = req_entry_data; p_st_in = ST_OK; p_adj_in = '0;
               push_after_in = 1'b0; didx_in = '0; state_in = S_RESP;
               case (req_operation)
                  OP_PUSH: begin
                     if (locked_ff && (fill_ff < FILL_W'(RESERVE_DEPTH))) begin
                        res_we = 1'b1; fill_in = fill_ff + 1'b1;
                     end else begin
                        locked_in = 1'b0; push_after_in = 1'b1;
                        state_in = (locked_ff && fill_ff != '0) ? S_DRAIN : S_WAIT;
                     end
                  end
                  OP_READ: begin
                     cnt_in = n_cnt; rd_in = '0;
                     raddr_in = PTR_W'(32'(wptr_ff) - held32 + s_off);
                     state_in = (n_cnt == '0) ? S_RESP : S_READ;
                  end
                  OP_CHECK: begin
                     if (held_ff == '0) begin
                        p_st_in = ST_BEYOND; p_adj_in = seq_ff;
                     end else if ((req_start_index - first_seq) < held32) begin
                        p_st_in = ST_OK; p_adj_in = req_start_index;
                     end else if (!chk_back[31]) begin
                        p_st_in = ST_OLD; p_adj_in = first_seq;
                     end else begin
                        p_st_in = ST_BEYOND; p_adj_in = seq_ff - 32'd1;
                     end
                  end
                  OP_LOCK:   locked_in = 1'b1;
                  OP_UNLOCK: begin
                     locked_in = 1'b0;
                     if (fill_ff != '0) state_in = S_DRAIN;
                  end
                  default: ;
               endcase
               if (req_operation == OP_READ && n_cnt == '0) cnt_in = '0;
            end
         end
         S_DRAIN: begin
            mem_req = '{wr_en: 1'b1, addr: wptr_ff, wdata: res_rdata_ff};
            wptr_in = wptr_ff + 1'b1;
            if (held_ff != HELD_W'(CAPACITY)) held_in = held_ff + 1'b1;
            seq_in = seq_ff + 32'd1;
            didx_in = didx_ff + 1'b1;
            if (FILL_W'(didx_ff) + 1'b1 == fill_ff) begin
               fill_in = '0;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (push_after_ff) begin
               mem_req = '{wr_en: 1'b1, addr: wptr_ff, wdata: pend_ff[PAYLOAD_WIDTH-1:0]};
               wptr_in = wptr_ff + 1'b1;
               if (held_ff != HELD_W'(CAPACITY)) held_in = held_ff + 1'b1;
               seq_in = seq_ff + 32'd1;
               push_after_in = 1'b0;
            end
            state_in = S_RESP;
         end
         S_READ: begin
            // Issue a read only when the result register is sure to be empty on its return.
            if (out_free && !rdv_ff && rd_ff != cnt_ff) begin
               mem_req.addr = raddr_ff;
               raddr_in = raddr_ff + 1'b1;
               rd_in = rd_ff + 1'b1;
               rdv_in = 1'b1;
               rdlast_in = (rd_ff + 1'b1 == cnt_ff);
            end
            if (rdv_ff) begin
               rsp_valid_in = 1'b1; o_data_in = mem_rdata; o_dv_in = 1'b1;
               o_st_in = ST_OK; o_adj_in = '0; o_cnt_in = cnt_ff;
               o_last_in = rdlast_ff;
               if (rdlast_ff) state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1; o_data_in = '0; o_dv_in = 1'b0;
               o_st_in = p_st_ff; o_adj_in = p_adj_ff; o_cnt_in = '0;
               o_last_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; wptr_ff <= '0; held_ff <= '0; seq_ff <= '0;
         fill_ff <= '0; locked_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         rdv_ff <= 1'b0; rdlast_ff <= 1'b0; push_after_ff <= 1'b0;
         didx_ff <= '0; cnt_ff <= '0; rd_ff <= '0;
      end else begin
         state_ff <= state_in; wptr_ff <= wptr_in; held_ff <= held_in;
         seq_ff <= seq_in; fill_ff <= fill_in; locked_ff <= locked_in;
         rsp_valid_ff <= rsp_valid_in; rdv_ff <= rdv_in; rdlast_ff <= rdlast_in;
         push_after_ff <= push_after_in; didx_ff <= didx_in;
         cnt_ff <= cnt_in; rd_ff <= rd_in;
      end
      pend_ff <= pend_in; raddr_ff <= raddr_in; p_st_ff <= p_st_in;
      p_adj_ff <= p_adj_in; o_data_ff <= o_data_in; o_dv_ff <= o_dv_in;
      o_st_ff <= o_st_in; o_adj_ff <= o_adj_in; o_cnt_ff <= o_cnt_in;
      o_last_ff <= o_last_in;
   end

   // Window fields reflect state after the operation; it is stable while a result waits.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = o_data_ff;
   assign rsp_data_valid     = o_dv_ff;
   assign rsp_status         = o_st_ff;
   assign rsp_clamped_index  = o_adj_ff;
   assign rsp_burst_count    = o_cnt_ff;
   assign rsp_first_index    = first_seq;
   assign rsp_next_index     = seq_ff;
   assign rsp_held_count     = held_ff;
   assign rsp_last           = o_last_ff;
endmodule
`default_nettype wire
